FILE: design/assert_macros.svh
// Assertion macros used by the timer table top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define PTT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define PTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ptt_pkg.sv
// Types and constants of the periodic task timer table.
package ptt_pkg;

    localparam int MAX_RESULTS  = 32;
    localparam int RES_CNT_BITS = 6;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_REQUEST = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    localparam logic [2:0] KIND_GRANTED  = 3'd0;
    localparam logic [2:0] KIND_FULL     = 3'd1;
    localparam logic [2:0] KIND_RELEASED = 3'd2;
    localparam logic [2:0] KIND_WAKE     = 3'd3;
    localparam logic [2:0] KIND_IDLE     = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  task_id;
        logic [15:0] period;
        logic [4:0]  slot;
    } req_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [4:0] slot_index;
        logic [7:0] wake_task;
        logic       last;
    } rsp_t;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_REQUEST,
        CMD_RELEASE,
        CMD_NOP
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [7:0]  task_id;
        logic [15:0] period;
        logic [4:0]  slot;
    } cmd_entry_t;

    typedef struct packed {
        logic       valid;
        cmd_entry_t entry;
    } queue_head_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } back_state_t;

endpackage

FILE: design/ptt_front.sv
// Request intake: decodes each request into a command and queues it for the back end.
module ptt_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  ptt_pkg::req_t        req,
    output logic                 busy,
    input  logic                 pop,
    output ptt_pkg::queue_head_t head
);

    ptt_pkg::cmd_entry_t ent_reg [2];
    ptt_pkg::cmd_entry_t new_ent;
    logic                wr_ptr_reg;
    logic                wr_ptr_next;
    logic                rd_ptr_reg;
    logic                rd_ptr_next;
    logic [1:0]          cnt_reg;
    logic [1:0]          cnt_next;
    logic                accept;
    logic                do_pop;

    assign busy   = (cnt_reg == 2'd2);
    assign accept = start && !busy;
    assign do_pop = pop && (cnt_reg != 2'd0);

    always_comb
    begin
        new_ent         = '0;
        new_ent.task_id = req.task_id;
        new_ent.period  = req.period;
        new_ent.slot    = req.slot;
        case (req.operation)
            ptt_pkg::OP_TICK:    new_ent.cmd = ptt_pkg::CMD_TICK;
            ptt_pkg::OP_REQUEST: new_ent.cmd = ptt_pkg::CMD_REQUEST;
            ptt_pkg::OP_RELEASE: new_ent.cmd = ptt_pkg::CMD_RELEASE;
            default:             new_ent.cmd = ptt_pkg::CMD_NOP;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = accept ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, accept} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ent_reg[wr_ptr_reg] <= new_ent;
        end
    end

    assign head.valid = (cnt_reg != 2'd0);
    assign head.entry = ent_reg[rd_ptr_reg];

endmodule

FILE: design/ptt_back.sv
// Command execution: slot memory, scan sequencer and result register.
module ptt_back
#(
    parameter int SLOTS      = 32,
    parameter int TASK_BITS  = 8,
    parameter int COUNT_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ptt_pkg::queue_head_t head,
    output logic                 pop,
    output logic                 res_valid,
    output ptt_pkg::rsp_t        res
);

    localparam int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ISS_BITS = $clog2(SLOTS + 1);
    localparam int ENT_W    = TASK_BITS + 2 * COUNT_BITS;
    localparam logic [ISS_BITS-1:0] ISS_END  = ISS_BITS'(SLOTS);
    localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(SLOTS - 1);
    localparam logic [8:0]          SLOT_LIM = 9'(SLOTS);
    localparam logic [ptt_pkg::RES_CNT_BITS-1:0] WAKE_CAP =
        ptt_pkg::RES_CNT_BITS'(ptt_pkg::MAX_RESULTS);

    function automatic ptt_pkg::rsp_t make_rsp(
        input logic [2:0] kind,
        input logic [4:0] idx,
        input logic [7:0] task_id,
        input logic       last
    );
        ptt_pkg::rsp_t r;
        r.kind       = kind;
        r.slot_index = idx;
        r.wake_task  = task_id;
        r.last       = last;
        return r;
    endfunction

    logic [ENT_W-1:0]          mem [SLOTS];
    logic [ENT_W-1:0]          rd_data_reg;
    logic                      rd_ok_reg;

    ptt_pkg::back_state_t      state_reg;
    ptt_pkg::back_state_t      state_next;
    ptt_pkg::cmd_entry_t       cur_reg;
    logic                      cur_load;
    logic [ISS_BITS-1:0]       iss_reg;
    logic [ISS_BITS-1:0]       iss_next;
    logic                      stg_vld_reg;
    logic                      stg_vld_next;
    logic [IDX_BITS-1:0]       stg_idx_reg;
    logic [IDX_BITS-1:0]       stg_idx_next;
    logic [SLOTS-1:0]          valid_reg;
    logic [SLOTS-1:0]          valid_next;
    logic [ptt_pkg::RES_CNT_BITS-1:0] wake_cnt_reg;
    logic [ptt_pkg::RES_CNT_BITS-1:0] wake_cnt_next;
    logic                      pend_vld_reg;
    logic                      pend_vld_next;
    logic [IDX_BITS-1:0]       pend_idx_reg;
    logic [IDX_BITS-1:0]       pend_idx_next;
    logic [TASK_BITS-1:0]      pend_task_reg;
    logic [TASK_BITS-1:0]      pend_task_next;
    logic                      res_valid_reg;
    logic                      res_valid_next;
    ptt_pkg::rsp_t             res_reg;
    ptt_pkg::rsp_t             res_next;

    logic                      rd_en;
    logic [IDX_BITS-1:0]       rd_addr;
    logic                      wr_en;
    logic [IDX_BITS-1:0]       wr_addr;
    logic [ENT_W-1:0]          wr_data;

    logic [ENT_W-1:0]          ent_d;
    logic [TASK_BITS-1:0]      task_q;
    logic [COUNT_BITS-1:0]     reload_q;
    logic [COUNT_BITS-1:0]     count_q;
    logic                      is_tick;
    logic                      is_req;
    logic                      proc;
    logic                      found;
    logic                      at_end;
    logic                      cap_ok;
    logic [TASK_BITS+7:0]      task_in_ext;
    logic [TASK_BITS-1:0]      task_in;
    logic [COUNT_BITS+15:0]    per_in_ext;
    logic [COUNT_BITS-1:0]     per_in;
    logic [IDX_BITS+4:0]       rel_idx_ext;
    logic [IDX_BITS-1:0]       rel_idx;
    logic                      rel_in_range;
    logic [IDX_BITS+4:0]       stg_idx_ext;
    logic [IDX_BITS+4:0]       pend_idx_ext;
    logic [TASK_BITS+7:0]      pend_task_ext;

    always_comb
    begin
        ent_d         = rd_ok_reg ? rd_data_reg : '0;
        task_q        = ent_d[ENT_W-1 -: TASK_BITS];
        reload_q      = ent_d[2*COUNT_BITS-1 -: COUNT_BITS];
        count_q       = ent_d[COUNT_BITS-1:0];
        is_tick       = (cur_reg.cmd == ptt_pkg::CMD_TICK);
        is_req        = (cur_reg.cmd == ptt_pkg::CMD_REQUEST);
        proc          = (state_reg == ptt_pkg::ST_SCAN) && stg_vld_reg;
        found         = proc && is_req && (task_q == '0);
        at_end        = proc && (stg_idx_reg == IDX_LAST);
        cap_ok        = (wake_cnt_reg < WAKE_CAP);
        task_in_ext   = {{TASK_BITS{1'b0}}, cur_reg.task_id};
        task_in       = task_in_ext[TASK_BITS-1:0];
        per_in_ext    = {{COUNT_BITS{1'b0}}, cur_reg.period};
        per_in        = per_in_ext[COUNT_BITS-1:0];
        rel_idx_ext   = {{IDX_BITS{1'b0}}, head.entry.slot};
        rel_idx       = rel_idx_ext[IDX_BITS-1:0];
        rel_in_range  = ({4'b0, head.entry.slot} < SLOT_LIM);
        stg_idx_ext   = {5'b0, stg_idx_reg};
        pend_idx_ext  = {5'b0, pend_idx_reg};
        pend_task_ext = {8'b0, pend_task_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ptt_pkg::ST_IDLE:
            begin
                if (head.valid && (head.entry.cmd == ptt_pkg::CMD_TICK ||
                                   head.entry.cmd == ptt_pkg::CMD_REQUEST))
                begin
                    state_next = ptt_pkg::ST_SCAN;
                end
            end
            ptt_pkg::ST_SCAN:
            begin
                if (found)
                begin
                    state_next = ptt_pkg::ST_IDLE;
                end
                else if (at_end)
                begin
                    state_next = ptt_pkg::ST_FINISH;
                end
            end
            ptt_pkg::ST_FINISH:
            begin
                state_next = ptt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ptt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop            = 1'b0;
        cur_load       = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = iss_reg[IDX_BITS-1:0];
        wr_en          = 1'b0;
        wr_addr        = stg_idx_reg;
        wr_data        = ent_d;
        valid_next     = valid_reg;
        iss_next       = iss_reg;
        stg_vld_next   = 1'b0;
        stg_idx_next   = iss_reg[IDX_BITS-1:0];
        wake_cnt_next  = wake_cnt_reg;
        pend_vld_next  = pend_vld_reg;
        pend_idx_next  = pend_idx_reg;
        pend_task_next = pend_task_reg;
        res_valid_next = 1'b0;
        res_next       = '0;
        case (state_reg)
            ptt_pkg::ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop           = 1'b1;
                    cur_load      = 1'b1;
                    iss_next      = '0;
                    wake_cnt_next = '0;
                    pend_vld_next = 1'b0;
                    case (head.entry.cmd)
                        ptt_pkg::CMD_RELEASE:
                        begin
                            res_valid_next = 1'b1;
                            res_next = make_rsp(ptt_pkg::KIND_RELEASED, head.entry.slot,
                                                8'd0, 1'b1);
                            if (rel_in_range)
                            begin
                                valid_next[rel_idx] = 1'b0;
                            end
                        end
                        ptt_pkg::CMD_NOP:
                        begin
                            res_valid_next = 1'b1;
                            res_next = make_rsp(ptt_pkg::KIND_IDLE, 5'd0, 8'd0, 1'b1);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ptt_pkg::ST_SCAN:
            begin
                if (iss_reg != ISS_END && !found)
                begin
                    rd_en        = 1'b1;
                    iss_next     = iss_reg + 1'b1;
                    stg_vld_next = 1'b1;
                end
                if (proc && is_tick)
                begin
                    if (count_q != '0)
                    begin
                        wr_en   = 1'b1;
                        wr_data = {task_q, reload_q, count_q - 1'b1};
                    end
                    else if (task_q != '0)
                    begin
                        wr_en   = 1'b1;
                        wr_data = {task_q, reload_q, reload_q};
                        if (cap_ok)
                        begin
                            wake_cnt_next  = wake_cnt_reg + 1'b1;
                            pend_vld_next  = 1'b1;
                            pend_idx_next  = stg_idx_reg;
                            pend_task_next = task_q;
                            if (pend_vld_reg)
                            begin
                                res_valid_next = 1'b1;
                                res_next = make_rsp(ptt_pkg::KIND_WAKE, pend_idx_ext[4:0],
                                                    pend_task_ext[7:0], 1'b0);
                            end
                        end
                    end
                end
                else if (found)
                begin
                    wr_en                   = 1'b1;
                    wr_data                 = {task_in, per_in, per_in};
                    valid_next[stg_idx_reg] = 1'b1;
                    res_valid_next          = 1'b1;
                    res_next = make_rsp(ptt_pkg::KIND_GRANTED, stg_idx_ext[4:0],
                                        8'd0, 1'b1);
                end
            end
            ptt_pkg::ST_FINISH:
            begin
                res_valid_next = 1'b1;
                if (is_tick && pend_vld_reg)
                begin
                    res_next = make_rsp(ptt_pkg::KIND_WAKE, pend_idx_ext[4:0],
                                        pend_task_ext[7:0], 1'b1);
                end
                else if (is_tick)
                begin
                    res_next = make_rsp(ptt_pkg::KIND_IDLE, 5'd0, 8'd0, 1'b1);
                end
                else
                begin
                    res_next = make_rsp(ptt_pkg::KIND_FULL, 5'd0, 8'd0, 1'b1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ptt_pkg::ST_IDLE;
            iss_reg       <= '0;
            stg_vld_reg   <= 1'b0;
            valid_reg     <= '0;
            wake_cnt_reg  <= '0;
            pend_vld_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_reg       <= iss_next;
            stg_vld_reg   <= stg_vld_next;
            valid_reg     <= valid_next;
            wake_cnt_reg  <= wake_cnt_next;
            pend_vld_reg  <= pend_vld_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cur_load)
        begin
            cur_reg <= head.entry;
        end
        stg_idx_reg   <= stg_idx_next;
        pend_idx_reg  <= pend_idx_next;
        pend_task_reg <= pend_task_next;
        res_reg       <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_ok_reg   <= valid_reg[rd_addr];
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: design/periodic_task_timer_table_top.sv
// Top level of the periodic task timer table: intake queue, scan back end and checks.
//
// A request is taken when start is high and busy is low; a two-entry queue holds requests
// while the back end works, so busy rises only when both entries are taken. Every result
// appears on res for one cycle with res_valid high and must be taken then. A release or an
// unknown operation is answered without a scan. A tick scans the slot memory through its
// single read port, one slot a cycle, with a registered read; its wakes come out during the
// scan in slot order, the final one marked last, or one idle result when nothing wakes. A
// slot request stops at the first free slot, or ends with a full result when the table is
// full. Reset frees every slot at once through per-slot valid flags, so no clearing pass
// follows reset.
`include "assert_macros.svh"

module periodic_task_timer_table_top
#(
    parameter int SLOTS      = 32,
    parameter int TASK_BITS  = 8,
    parameter int COUNT_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  ptt_pkg::req_t req,
    output logic          busy,
    output logic          res_valid,
    output ptt_pkg::rsp_t res
);

    ptt_pkg::queue_head_t q_head;
    logic                 q_pop;

    ptt_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .pop   (q_pop),
        .head  (q_head)
    );

    ptt_back
    #(
        .SLOTS      (SLOTS),
        .TASK_BITS  (TASK_BITS),
        .COUNT_BITS (COUNT_BITS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .pop       (q_pop),
        .res_valid (res_valid),
        .res       (res)
    );

    `PTT_ASSERT_NEXT(a_accept_queued, clk, rst_n, start && !busy, q_head.valid, "accepted request not queued")
    `PTT_ASSERT_IMPL(a_plain_result, clk, rst_n, res_valid && (res.kind == ptt_pkg::KIND_IDLE || res.kind == ptt_pkg::KIND_FULL), res.last && res.slot_index == 5'd0 && res.wake_task == 8'd0, "idle or full result malformed")
    `PTT_ASSERT_IMPL(a_wake_task, clk, rst_n, res_valid && res.kind == ptt_pkg::KIND_WAKE, res.wake_task != 8'd0, "wake without task id")

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the periodic task timer table top level.
`timescale 1ns / 100ps

module tb;

    localparam int         SLOTS       = 32;
    localparam int         RANDOM_REQS = 400;
    localparam int         IDLE_LIMIT  = 2000;
    localparam int         DRAIN_WAIT  = 40;
    localparam logic [1:0] OP_NOP      = 2'd3;

    logic           clk   = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    ptt_pkg::req_t  req   = '0;
    logic           busy;
    logic           res_valid;
    ptt_pkg::rsp_t  res;

    ptt_pkg::req_t  pending_req [$];
    ptt_pkg::rsp_t  expected_rsp [$];

    logic [7:0]  slot_task   [SLOTS];
    logic [15:0] slot_reload [SLOTS];
    logic [15:0] slot_count  [SLOTS];

    int    mismatches  = 0;
    int    idle_cycles = 0;
    int    burst_left  = 1;
    int    gap_left    = 0;

    periodic_task_timer_table_top DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .res_valid (res_valid),
        .res       (res)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic ptt_pkg::rsp_t make_rsp(logic [2:0] kind, logic [4:0] idx,
                                               logic [7:0] id, logic last);
        ptt_pkg::rsp_t r;
        r.kind       = kind;
        r.slot_index = idx;
        r.wake_task  = id;
        r.last       = last;
        return r;
    endfunction

    function automatic void apply_request(ptt_pkg::req_t r);
        ptt_pkg::rsp_t held;
        int   wakes;
        int   i;
        logic found;
        wakes = 0;
        found = 1'b0;
        held  = '0;
        case (r.operation)
            ptt_pkg::OP_TICK:
            begin
                for (i = 0; i < SLOTS; i++)
                begin
                    if (slot_count[i] != 16'd0)
                        slot_count[i] = slot_count[i] - 16'd1;
                    else if (slot_task[i] != 8'd0)
                    begin
                        slot_count[i] = slot_reload[i];
                        if (wakes < ptt_pkg::MAX_RESULTS)
                        begin
                            if (wakes != 0)
                                expected_rsp.push_back(held);
                            held = make_rsp(ptt_pkg::KIND_WAKE, 5'(i), slot_task[i], 1'b0);
                            wakes++;
                        end
                    end
                end
                if (wakes == 0)
                    expected_rsp.push_back(make_rsp(ptt_pkg::KIND_IDLE, 5'd0, 8'd0, 1'b1));
                else
                begin
                    held.last = 1'b1;
                    expected_rsp.push_back(held);
                end
            end
            ptt_pkg::OP_REQUEST:
            begin
                for (i = 0; i < SLOTS; i++)
                begin
                    if (!found && slot_task[i] == 8'd0)
                    begin
                        found          = 1'b1;
                        slot_count[i]  = r.period;
                        slot_reload[i] = r.period;
                        slot_task[i]   = r.task_id;
                        expected_rsp.push_back(
                            make_rsp(ptt_pkg::KIND_GRANTED, 5'(i), 8'd0, 1'b1));
                    end
                end
                if (!found)
                    expected_rsp.push_back(make_rsp(ptt_pkg::KIND_FULL, 5'd0, 8'd0, 1'b1));
            end
            ptt_pkg::OP_RELEASE:
            begin
                if (int'(r.slot) < SLOTS)
                begin
                    slot_count[r.slot]  = 16'd0;
                    slot_reload[r.slot] = 16'd0;
                    slot_task[r.slot]   = 8'd0;
                end
                expected_rsp.push_back(make_rsp(ptt_pkg::KIND_RELEASED, r.slot, 8'd0, 1'b1));
            end
            default:
                expected_rsp.push_back(make_rsp(ptt_pkg::KIND_IDLE, 5'd0, 8'd0, 1'b1));
        endcase
    endfunction

    task automatic add_req(logic [1:0] op, logic [7:0] id, logic [15:0] per, logic [4:0] sl);
        ptt_pkg::req_t r;
        r.operation = op;
        r.task_id   = id;
        r.period    = per;
        r.slot      = sl;
        pending_req.push_back(r);
    endtask

    // Drive requests in bursts; hold start while busy.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req   <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                apply_request(req);
                void'(pending_req.pop_front());
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 :
                                 (($urandom_range(0, 7) == 0) ? $urandom_range(40, 90) :
                                                                $urandom_range(1, 12));
                end
                else
                    burst_left--;
            end
            else if (!start && gap_left != 0)
                gap_left--;
            if (gap_left == 0 && pending_req.size() != 0)
            begin
                start <= 1'b1;
                req   <= pending_req[0];
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        ptt_pkg::rsp_t exp_r;
        if (rst_n && res_valid)
        begin
            if (expected_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result kind=%0d slot=%0d task=%0d last=%0b",
                             res.kind, res.slot_index, res.wake_task, res.last);
            end
            else
            begin
                exp_r = expected_rsp.pop_front();
                if (res.kind != exp_r.kind || res.slot_index != exp_r.slot_index ||
                    res.wake_task != exp_r.wake_task || res.last != exp_r.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ERROR: expected kind=%0d slot=%0d task=%0d last=%0b",
                                 exp_r.kind, exp_r.slot_index, exp_r.wake_task, exp_r.last);
                        $display("       got      kind=%0d slot=%0d task=%0d last=%0b",
                                 res.kind, res.slot_index, res.wake_task, res.last);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || res_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        int         i;
        int         roll;
        int         w_req;
        int         w_rel;
        logic [1:0] op;
        logic [7:0] id;
        logic [15:0] per;
        for (i = 0; i < SLOTS; i++)
        begin
            slot_task[i]   = 8'd0;
            slot_reload[i] = 16'd0;
            slot_count[i]  = 16'd0;
        end

        add_req(ptt_pkg::OP_TICK,    8'hFF, 16'hFFFF, 5'd31);
        add_req(OP_NOP,              8'hAA, 16'h5555, 5'd21);
        add_req(ptt_pkg::OP_REQUEST, 8'hFF, 16'd0,    5'd0);
        add_req(ptt_pkg::OP_REQUEST, 8'd0,  16'hFFFF, 5'd31);
        add_req(ptt_pkg::OP_REQUEST, 8'd1,  16'hFFFF, 5'd0);
        add_req(ptt_pkg::OP_REQUEST, 8'h80, 16'd1,    5'd0);
        add_req(ptt_pkg::OP_TICK,    8'd0,  16'd0,    5'd0);
        add_req(ptt_pkg::OP_TICK,    8'd0,  16'd0,    5'd0);
        add_req(ptt_pkg::OP_REQUEST, 8'd0,  16'd2,    5'd0);
        add_req(ptt_pkg::OP_TICK,    8'd0,  16'd0,    5'd0);
        add_req(ptt_pkg::OP_RELEASE, 8'd0,  16'd0,    5'd0);
        add_req(ptt_pkg::OP_RELEASE, 8'hFF, 16'hFFFF, 5'd31);
        add_req(ptt_pkg::OP_REQUEST, 8'h7F, 16'h8000, 5'd0);
        add_req(ptt_pkg::OP_TICK,    8'd0,  16'd0,    5'd0);
        add_req(ptt_pkg::OP_RELEASE, 8'd0,  16'd0,    5'd2);
        add_req(ptt_pkg::OP_TICK,    8'd0,  16'd0,    5'd0);
        add_req(OP_NOP,              8'd0,  16'd0,    5'd0);

        for (i = 0; i < RANDOM_REQS; i++)
        begin
            case (i / 100)
                0:       begin w_req = 70; w_rel = 3;  end
                1:       begin w_req = 20; w_rel = 18; end
                2:       begin w_req = 18; w_rel = 50; end
                default: begin w_req = 33; w_rel = 25; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < w_req)
                op = ptt_pkg::OP_REQUEST;
            else if (roll < w_req + w_rel)
                op = ptt_pkg::OP_RELEASE;
            else if (roll < w_req + w_rel + 2)
                op = OP_NOP;
            else
                op = ptt_pkg::OP_TICK;
            id = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            roll = $urandom_range(0, 99);
            if (roll < 60)
                per = 16'($urandom_range(0, 4));
            else if (roll < 85)
                per = 16'($urandom_range(5, 40));
            else
                per = 16'($urandom_range(0, 65535));
            add_req(op, id, per, 5'($urandom_range(0, 31)));
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_req.size() != 0 || expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0 && expected_rsp.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/ptt_pkg.sv
design/ptt_front.sv
design/ptt_back.sv
design/periodic_task_timer_table_top.sv
verif/tb.sv
